// File: rtl/core/secure_freshness_value_manager_macros.svh
// Assertion macros used by the freshness manager control module.
`ifndef SECURE_FRESHNESS_VALUE_MANAGER_MACROS_SVH
`define SECURE_FRESHNESS_VALUE_MANAGER_MACROS_SVH
`define SFVM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SFVM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/core/sfvm_pkg.sv
package sfvm_pkg;
    localparam int unsigned TxSlotsDef = 16;
    localparam int unsigned RxSlotsDef = 16;
    localparam int unsigned IdW = 29;
    localparam int unsigned CntW = 22;
    localparam int unsigned TripW = 24;
    localparam int unsigned RstW = 16;
    localparam int unsigned UsedW = 5;
    localparam int unsigned InW = 107;
    localparam int unsigned OutW = 88;

    localparam logic [2:0] REQ_TX = 3'd0;
    localparam logic [2:0] REQ_RX = 3'd1;
    localparam logic [2:0] REQ_SYNC = 3'd2;
    localparam logic [2:0] REQ_LOAD = 3'd3;
    localparam logic [2:0] REQ_SET = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_WINDOW = 2'd2;
    localparam logic [1:0] ST_STALE = 2'd3;

    localparam logic CFG_TX_USED = 1'b0;

    typedef struct packed {
        logic       load;
        logic       search_step;
        logic       search_init;
        logic       execute;
        logic       sync_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic search_done;
        logic sync_done;
        logic is_sync;
    } t_sts;
endpackage

// File: rtl/core/sfvm_datapath.sv
module sfvm_datapath
    import sfvm_pkg::*;
#(
    parameter int unsigned TX_SLOTS = TxSlotsDef,
    parameter int unsigned RX_SLOTS = RxSlotsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [InW-1:0]  i_req,
    input  logic [UsedW-1:0] i_tx_used,
    input  logic [UsedW-1:0] i_rx_used,
    input  t_cmd            i_cmd,
    output t_sts            o_sts,
    output logic [OutW-1:0] o_result
);
    localparam int unsigned TxIw = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
    localparam int unsigned RxIw = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
    localparam int unsigned MaxS = (TX_SLOTS > RX_SLOTS) ? TX_SLOTS : RX_SLOTS;
    localparam int unsigned SW = $clog2(MaxS + 1);

    logic [InW-1:0] r_req;
    logic [2:0] req_type;
    logic [IdW-1:0] msg_id;
    logic dir_rx;
    logic [3:0] slot_index;
    logic [5:0] clow;
    logic [1:0] rlow;
    logic [TripW-1:0] strip;
    logic [RstW-1:0] srst;
    logic [CntW-1:0] cval;
    assign {cval, srst, strip, rlow, clow, slot_index, dir_rx, msg_id, req_type} = r_req;

    logic [TripW-1:0] r_trip;
    logic [RstW-1:0] r_rst;
    logic [IdW-1:0] r_tx_id [TX_SLOTS];
    logic [IdW-1:0] r_rx_id [RX_SLOTS];
    logic [CntW-1:0] r_tx_cnt [TX_SLOTS];
    logic [CntW-1:0] r_rx_cnt [RX_SLOTS];
    logic [TripW-1:0] r_rx_ltrip [RX_SLOTS];
    logic [RstW-1:0] r_rx_lrst [RX_SLOTS];

    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_limit;
    logic r_found;
    logic [SW-1:0] r_slot;
    logic [SW-1:0] txn, rxn;
    logic use_rx;
    logic [IdW-1:0] cur_id;
    logic [SW:0] n_sync;
    logic [1:0] r_status;
    logic [63:0] r_fresh;
    logic [CntW-1:0] r_cnt;

    assign txn = (32'(i_tx_used) > TX_SLOTS) ? SW'(TX_SLOTS) : SW'(i_tx_used);
    assign rxn = (32'(i_rx_used) > RX_SLOTS) ? SW'(RX_SLOTS) : SW'(i_rx_used);
    assign use_rx = (req_type == REQ_RX) || (req_type == REQ_SET && dir_rx);
    always_comb begin
        cur_id = '0;
        if (use_rx) begin
            if (r_idx < SW'(RX_SLOTS)) cur_id = r_rx_id[r_idx[RxIw-1:0]];
        end else begin
            if (r_idx < SW'(TX_SLOTS)) cur_id = r_tx_id[r_idx[TxIw-1:0]];
        end
    end
    assign n_sync = {1'b0, r_idx} + 1'b1;

    assign o_sts.search_done = r_found || (r_idx >= r_limit);
    assign o_sts.sync_done = (r_idx >= r_limit);
    assign o_sts.is_sync = (req_type == REQ_SYNC);
    assign o_result = {r_cnt, r_fresh, r_status};

    // Receive reconstruction, computed from the found slot.
    logic [RxIw-1:0] rs;
    logic [TxIw-1:0] ts;
    logic signed [2:0] d;
    logic [41:0] cur, last;
    logic [CntW-1:0] m, hi, tc;
    assign rs = r_slot[RxIw-1:0];
    assign ts = r_slot[TxIw-1:0];
    assign d = $signed({1'b0, rlow}) - $signed({1'b0, r_rst[1:0]});
    assign cur = {2'b0, r_trip, r_rst} + {{39{d[2]}}, d};
    assign last = {2'b0, r_rx_ltrip[rs], r_rx_lrst[rs]};
    assign m = r_rx_cnt[rs];
    assign tc = r_tx_cnt[ts];
    always_comb begin
        hi = {m[CntW-1:6], 6'b0};
        if (clow <= m[5:0]) hi = hi + CntW'(64);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip <= '0;
            r_rst <= '0;
            for (int k = 0; k < TX_SLOTS; k++) begin
                r_tx_id[k] <= '0;
                r_tx_cnt[k] <= CntW'(1);
            end
            for (int k = 0; k < RX_SLOTS; k++) begin
                r_rx_id[k] <= '0;
                r_rx_cnt[k] <= CntW'(1);
                r_rx_ltrip[k] <= '0;
                r_rx_lrst[k] <= '0;
            end
            r_idx <= '0;
            r_limit <= '0;
            r_found <= 1'b0;
            r_slot <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req <= i_req;
            end
            if (i_cmd.search_init) begin
                r_idx <= '0;
                r_found <= 1'b0;
                if (req_type == REQ_SYNC) r_limit <= (txn > rxn) ? txn : rxn;
                else r_limit <= use_rx ? rxn : txn;
            end
            if (i_cmd.search_step) begin
                if (cur_id == msg_id) begin
                    r_found <= 1'b1;
                    r_slot <= r_idx;
                end else begin
                    r_idx <= n_sync[SW-1:0];
                end
            end
            if (i_cmd.sync_step) begin
                if (r_idx < txn && r_idx < SW'(TX_SLOTS)) r_tx_cnt[r_idx[TxIw-1:0]] <= CntW'(1);
                if (r_idx < rxn && r_idx < SW'(RX_SLOTS)) r_rx_cnt[r_idx[RxIw-1:0]] <= CntW'(1);
                r_idx <= n_sync[SW-1:0];
            end
            if (i_cmd.execute) begin
                r_status <= ST_OK;
                r_fresh <= '0;
                r_cnt <= '0;
                case (req_type)
                    REQ_TX: begin
                        if (!r_found) r_status <= ST_NOT_FOUND;
                        else begin
                            r_tx_cnt[ts] <= (tc == '1) ? '0 : tc + 1'b1;
                            r_cnt <= tc;
                            r_fresh <= {r_trip, r_rst, tc, r_rst[1:0]};
                        end
                    end
                    REQ_RX: begin
                        if (!r_found) r_status <= ST_NOT_FOUND;
                        else if (d == 3'sd3 || d == -3'sd3) r_status <= ST_WINDOW;
                        else if (cur == last) begin
                            r_rx_cnt[rs] <= {hi[CntW-1:6], clow};
                            r_cnt <= {hi[CntW-1:6], clow};
                            r_fresh <= {r_rx_ltrip[rs], r_rx_lrst[rs],
                                        hi[CntW-1:6], clow, r_rst[1:0]};
                        end else if (cur > last) begin
                            r_rx_cnt[rs] <= CntW'(clow);
                            r_rx_ltrip[rs] <= r_trip;
                            r_rx_lrst[rs] <= cur[RstW-1:0];
                            r_cnt <= CntW'(clow);
                            r_fresh <= {r_trip, cur[RstW-1:0], CntW'(clow), r_rst[1:0]};
                        end else r_status <= ST_STALE;
                    end
                    REQ_SYNC: begin
                        r_trip <= strip;
                        r_rst <= srst;
                    end
                    REQ_LOAD: begin
                        if (dir_rx) begin
                            if ({5'd0, slot_index} < 9'(RX_SLOTS))
                                r_rx_id[RxIw'(slot_index)] <= msg_id;
                            else r_status <= ST_NOT_FOUND;
                        end else begin
                            if ({5'd0, slot_index} < 9'(TX_SLOTS))
                                r_tx_id[TxIw'(slot_index)] <= msg_id;
                            else r_status <= ST_NOT_FOUND;
                        end
                    end
                    REQ_SET: begin
                        if (!r_found) r_status <= ST_NOT_FOUND;
                        else begin
                            if (dir_rx) r_rx_cnt[rs] <= cval;
                            else r_tx_cnt[ts] <= cval;
                            r_cnt <= cval;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end
endmodule

// File: rtl/core/sfvm_ctrl.sv
`include "secure_freshness_value_manager_macros.svh"
module sfvm_ctrl
    import sfvm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SYNC = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;

    logic [2:0] r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.search_init = 1'b1;
                n_state = i_sts.is_sync ? S_SYNC : S_SEARCH;
            end
            S_SEARCH: begin
                if (i_sts.search_done) n_state = S_EXEC;
                else o_cmd.search_step = 1'b1;
            end
            S_SYNC: begin
                if (i_sts.sync_done) n_state = S_EXEC;
                else o_cmd.sync_step = 1'b1;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                o_cmd.out_load = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SFVM_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `SFVM_ASSERT_NXT(a_exec_valid, i_clk, i_rst_n, r_state == S_EXEC, r_out_valid)
    `SFVM_ASSERT_NXT(a_accept_init, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_INIT)
endmodule

// File: rtl/core/secure_freshness_value_manager.sv
// Freshness value manager for secured bus messages.
// Requests enter on the s_axis channel; tdata packs req_type, msg_id, dir_rx,
// slot_index, rx_count_low, rx_reset_low, sync_trip, sync_reset and
// counter_value from the lowest bit up. One result per request leaves on
// m_axis with status, freshness and slot_counter.
// The configuration channel writes tx_slots_used (index 0) and rx_slots_used
// (index 1). The user must write them only while the block is idle; the
// block itself does not enforce this. The identifier search compares one
// table entry per step, stopping at the matching entry or at the used
// count; sync steps through the slot indices up to the larger used count.
// One request is handled at a time; a new one is taken in the cycle after
// the previous result has been read.
// When the receiver stalls, the result is held in its output register and
// no further request is taken.
// Reset clears counters and tables to their initial values at once.
module secure_freshness_value_manager
    import sfvm_pkg::*;
#(
    parameter int unsigned TX_SLOTS = TxSlotsDef,
    parameter int unsigned RX_SLOTS = RxSlotsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // req_type, msg_id, dir_rx, slot_index, rx_count_low, rx_reset_low,
    // sync_trip, sync_reset, counter_value
    input  logic [111:0]     s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status, freshness, slot_counter
    output logic [87:0]      m_axis_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [UsedW-1:0] i_cfg_data
);
    logic [UsedW-1:0] r_tx_used, r_rx_used;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_used <= '0;
            r_rx_used <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TX_USED) r_tx_used <= i_cfg_data;
            else r_rx_used <= i_cfg_data;
        end
    end

    sfvm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    sfvm_datapath #(.TX_SLOTS(TX_SLOTS), .RX_SLOTS(RX_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(s_axis_tdata[InW-1:0]),
        .i_tx_used(r_tx_used), .i_rx_used(r_rx_used),
        .i_cmd(cmd), .o_sts(sts), .o_result(m_axis_tdata)
    );
endmodule
